@@ hdl/cxpc_pkg.sv @@
package cxpc_pkg;

    localparam int MAX_PAYLOAD_DEF = 63;

    localparam logic REG_STATIC_KEY = 1'b0;
    localparam logic REG_DIRECTION  = 1'b1;

    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    typedef struct packed {
        logic [7:0] plain;
        logic [7:0] cipher;
    } chain_t;

    // plain chain first, then cipher chain
    function automatic chain_t encrypt_byte(
        input logic [7:0] d,
        input logic [7:0] prev_plain,
        input logic [7:0] prev_cipher,
        input logic [7:0] pkt_key,
        input logic [7:0] stat_key,
        input logic [7:0] pos
    );
        chain_t r;
        r.plain  = d ^ (prev_plain + pkt_key + pos);
        r.cipher = r.plain ^ (prev_cipher + stat_key + pos);
        return r;
    endfunction

    // cipher chain first, then plain chain; returns the plain byte only (the intermediate is in decrypt_mid)
    function automatic logic [7:0] decrypt_byte(
        input logic [7:0] c,
        input logic [7:0] prev_plain,
        input logic [7:0] prev_cipher,
        input logic [7:0] pkt_key,
        input logic [7:0] stat_key,
        input logic [7:0] pos
    );
        logic [7:0] p;
        p = c ^ (prev_cipher + stat_key + pos);
        return p ^ (prev_plain + pkt_key + pos);
    endfunction

    function automatic logic [7:0] decrypt_mid(
        input logic [7:0] c,
        input logic [7:0] prev_cipher,
        input logic [7:0] stat_key,
        input logic [7:0] pos
    );
        return c ^ (prev_cipher + stat_key + pos);
    endfunction

endpackage

@@ hdl/cxpc_ram.sv @@
module cxpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/chained_xor_packet_cipher_unit.sv @@
// Byte-serial packet cipher with two XOR chains and a mod-256 checksum. A request is
// taken when start is high and busy is low; every result is registered and shows on
// out_byte, is_checksum and last_out, marked by out_valid for a single cycle, and must be
// captured then since the block cannot be held off. Decrypt takes one byte per cycle while
// busy is low and answers each with one byte on the next cycle. Encrypt stores one payload
// byte per cycle while busy is low into an internal RAM with no result; on the byte marked
// last, busy goes high while the checksum and then the stored payload are computed, one
// byte per cycle, the payload from the single read port of the payload RAM. Each of these
// results is registered and shows in the cycle after its busy cycle: the checksum in the
// cycle after busy rises, the last payload byte in the cycle in which busy is low again.
// At most MAX_PAYLOAD bytes are stored per packet; later bytes are dropped.
module chained_xor_packet_cipher_unit
    import cxpc_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic       wr_index,
    input  logic [7:0] wr_data,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] data_byte,
    input  logic [7:0] random_key,
    input  logic       first_of_packet,
    input  logic       last_of_packet,
    output logic       out_valid,
    output logic [7:0] out_byte,
    output logic       is_checksum,
    output logic       last_out
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CW = $clog2(MAX_PAYLOAD + 1);

    logic [7:0]    static_key_reg;
    logic          direction_reg;

    state_t        state_reg, state_next;
    logic [CW-1:0] step_reg, step_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    sum_reg, sum_next;
    logic [7:0]    pp_reg, pp_next;
    logic [7:0]    pc_reg, pc_next;
    logic [7:0]    pos_reg, pos_next;
    logic [7:0]    key_reg, key_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          is_checksum_reg, is_checksum_next;
    logic          last_out_reg, last_out_next;

    logic          accept;
    logic [CW-1:0] count_in;
    logic [7:0]    sum_in, pp_in, pc_in, pos_in, key_in, pos_inc;
    logic          can_store;
    logic          ram_wr, ram_rd;
    logic [7:0]    ram_rdata;
    logic [7:0]    dec_mid, dec_out;
    logic [7:0]    emit_src, emit_pos;
    chain_t        emit_enc;
    logic          emit_done;

    assign accept = start && !busy;
    assign busy   = (state_reg == ST_EMIT);

    // packet restart on first byte
    assign count_in = first_of_packet ? '0 : count_reg;
    assign sum_in   = first_of_packet ? 8'd0 : sum_reg;
    assign pp_in    = first_of_packet ? 8'd0 : pp_reg;
    assign pc_in    = first_of_packet ? 8'd0 : pc_reg;
    assign pos_in   = first_of_packet ? 8'd0 : pos_reg;
    assign key_in   = first_of_packet ? random_key : key_reg;
    assign pos_inc  = pos_in + 8'd1;

    assign can_store = (count_in < CW'(MAX_PAYLOAD));
    assign ram_wr    = accept && (direction_reg == DIR_ENCRYPT) && can_store;
    assign ram_rd    = busy && (step_reg < count_reg);

    cxpc_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (count_in[AW-1:0]),
        .wr_data (data_byte),
        .rd_en   (ram_rd),
        .rd_addr (step_reg[AW-1:0]),
        .rd_data (ram_rdata)
    );

    assign dec_mid = decrypt_mid(data_byte, pc_in, static_key_reg, pos_inc);
    assign dec_out = decrypt_byte(data_byte, pp_in, pc_in, key_in, static_key_reg, pos_inc);

    assign emit_src  = (step_reg == '0) ? sum_reg : ram_rdata;
    assign emit_pos  = pos_reg + 8'd1;
    assign emit_enc  = encrypt_byte(emit_src, pp_reg, pc_reg, key_reg, static_key_reg,
                                    emit_pos);
    assign emit_done = (step_reg == count_reg);

    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        count_next       = count_reg;
        sum_next         = sum_reg;
        pp_next          = pp_reg;
        pc_next          = pc_reg;
        pos_next         = pos_reg;
        key_next         = key_reg;
        out_valid_next   = 1'b0;
        out_byte_next    = out_byte_reg;
        is_checksum_next = is_checksum_reg;
        last_out_next    = last_out_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next = key_in;
                    if (direction_reg == DIR_DECRYPT)
                    begin
                        out_valid_next   = 1'b1;
                        out_byte_next    = dec_out;
                        is_checksum_next = (pos_in == 8'd0);
                        last_out_next    = last_of_packet;
                        if (last_of_packet)
                        begin
                            count_next = '0;
                            sum_next   = 8'd0;
                            pp_next    = 8'd0;
                            pc_next    = 8'd0;
                            pos_next   = 8'd0;
                        end
                        else
                        begin
                            count_next = count_in;
                            sum_next   = sum_in;
                            pp_next    = dec_mid;
                            pc_next    = data_byte;
                            pos_next   = pos_inc;
                        end
                    end
                    else
                    begin
                        pp_next    = pp_in;
                        pc_next    = pc_in;
                        pos_next   = pos_in;
                        count_next = can_store ? count_in + 1'b1 : count_in;
                        sum_next   = can_store ? sum_in + data_byte : sum_in;
                        if (last_of_packet)
                        begin
                            state_next = ST_EMIT;
                            step_next  = '0;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                out_valid_next   = 1'b1;
                out_byte_next    = emit_enc.cipher;
                is_checksum_next = (step_reg == '0);
                last_out_next    = emit_done;
                pp_next          = emit_enc.plain;
                pc_next          = emit_enc.cipher;
                pos_next         = emit_pos;
                step_next        = step_reg + 1'b1;
                if (emit_done)
                begin
                    state_next = ST_IDLE;
                    count_next = '0;
                    sum_next   = 8'd0;
                    pp_next    = 8'd0;
                    pc_next    = 8'd0;
                    pos_next   = 8'd0;
                    step_next  = '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            static_key_reg <= 8'd0;
            direction_reg  <= DIR_ENCRYPT;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_STATIC_KEY: static_key_reg <= wr_data;
                REG_DIRECTION:  direction_reg  <= wr_data[0];
                default:        static_key_reg <= static_key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= 8'd0;
            pp_reg        <= 8'd0;
            pc_reg        <= 8'd0;
            pos_reg       <= 8'd0;
            key_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            pp_reg        <= pp_next;
            pc_reg        <= pc_next;
            pos_reg       <= pos_next;
            key_reg       <= key_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg    <= out_byte_next;
        is_checksum_reg <= is_checksum_next;
        last_out_reg    <= last_out_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign is_checksum = is_checksum_reg;
    assign last_out    = last_out_reg;

`ifndef SYNTHESIS
    a_dec_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && direction_reg == DIR_DECRYPT) |=> out_valid)
        else $error("decrypt request without result");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (step_reg <= count_reg))
        else $error("readout step past stored count");

    a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && emit_done) |=> (!busy && out_valid && last_out))
        else $error("readout did not end with last result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_PAYLOAD))
        else $error("stored count beyond store depth");
`endif

endmodule
